// ----- src/rpv_pkg.sv -----
// Shared types and constants of the request path validator.
package rpv_pkg;

    // Input kinds carried in tuser.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Configuration register indexes (word address bits).
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_MSG_ID_LEN  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TAG_LEN     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ONION_LEN   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GARLIC_LEN  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_USER_LEN    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAX_BYTES   = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_MSG_ID_LEN = 8'd40;
    localparam logic [7:0] RST_TAG_LEN    = 8'd128;
    localparam logic [7:0] RST_ONION_LEN  = 8'd16;
    localparam logic [7:0] RST_GARLIC_LEN = 8'd52;
    localparam logic [7:0] RST_USER_LEN   = 8'd32;
    localparam logic [9:0] RST_MAX_BYTES  = 10'd512;

    typedef enum logic [2:0] {
        VERDICT_VER_OK      = 3'd0,
        VERDICT_MSG_OK      = 3'd1,
        VERDICT_RCP_OK      = 3'd2,
        VERDICT_ACK_OK      = 3'd3,
        VERDICT_BAD_FORMAT  = 3'd4,
        VERDICT_BAD_REQUEST = 3'd5
    } verdict_t;

    typedef struct packed {
        logic [7:0] message_id_length;
        logic [7:0] tag_length;
        logic [7:0] onion_prefix_length;
        logic [7:0] garlic_prefix_length;
        logic [7:0] user_name_length;
        logic [9:0] max_request_bytes;
    } cfg_t;

    typedef struct packed {
        verdict_t verdict;
        logic     host_network;
    } result_t;

endpackage

// ----- src/request_path_validator_core.sv -----
// Top level of the request path validator: input register, parser and result register.
//
// The block takes one request byte per cycle on the input stream and, for each end
// request (tuser high), returns one verdict on the output stream. An accepted request
// sits in the input register; the parser folds a byte request into the token state on
// the next edge, and an end request on the edge that loads its verdict into the result
// register. Input and result registers run independently: bytes keep flowing while a
// verdict waits, and the input stalls only when a second end request meets a verdict
// that has not been taken. Sustained rate is one request per cycle. Configuration
// registers lie at byte addresses 0x00 to 0x14. The user writes them only while no
// request is in flight; the block itself does not enforce this.
module request_path_validator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] verdict, [3] host_network, [7:4] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rpv_pkg::cfg_t    cfg;
    rpv_pkg::result_t result;

    logic             in_valid_reg, in_valid_next;
    logic             in_kind_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg, out_valid_next;
    rpv_pkg::result_t out_result_reg;
    logic             step;
    logic             load_result;
    logic             in_take;

    rpv_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rpv_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .kind      (in_kind_reg),
        .text_byte (in_byte_reg),
        .result    (result)
    );

    // A byte request never needs the result register, so only an end request waits.
    assign step = in_valid_reg &&
                  (in_kind_reg == rpv_pkg::KIND_BYTE || !out_valid_reg || m_axis_tready);
    assign load_result   = step && (in_kind_reg == rpv_pkg::KIND_END);
    assign s_axis_tready = !in_valid_reg || step;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_result_reg.host_network, out_result_reg.verdict};

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (load_result)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_kind_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
        if (load_result)
            out_result_reg <= result;
    end

endmodule

// ----- src/rpv_cfg_regs.sv -----
// APB-style configuration registers of the request path validator.
module rpv_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output rpv_pkg::cfg_t       cfg
);

    rpv_pkg::cfg_t cfg_reg;
    rpv_pkg::cfg_t cfg_next;
    logic [rpv_pkg::REG_IDX_W-1:0] reg_idx;
    logic wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                rpv_pkg::REG_MSG_ID_LEN: cfg_next.message_id_length    = pwdata[7:0];
                rpv_pkg::REG_TAG_LEN:    cfg_next.tag_length           = pwdata[7:0];
                rpv_pkg::REG_ONION_LEN:  cfg_next.onion_prefix_length  = pwdata[7:0];
                rpv_pkg::REG_GARLIC_LEN: cfg_next.garlic_prefix_length = pwdata[7:0];
                rpv_pkg::REG_USER_LEN:   cfg_next.user_name_length     = pwdata[7:0];
                rpv_pkg::REG_MAX_BYTES:  cfg_next.max_request_bytes    = pwdata[9:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            rpv_pkg::REG_MSG_ID_LEN: prdata = {24'd0, cfg_reg.message_id_length};
            rpv_pkg::REG_TAG_LEN:    prdata = {24'd0, cfg_reg.tag_length};
            rpv_pkg::REG_ONION_LEN:  prdata = {24'd0, cfg_reg.onion_prefix_length};
            rpv_pkg::REG_GARLIC_LEN: prdata = {24'd0, cfg_reg.garlic_prefix_length};
            rpv_pkg::REG_USER_LEN:   prdata = {24'd0, cfg_reg.user_name_length};
            rpv_pkg::REG_MAX_BYTES:  prdata = {22'd0, cfg_reg.max_request_bytes};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.message_id_length    <= rpv_pkg::RST_MSG_ID_LEN;
            cfg_reg.tag_length           <= rpv_pkg::RST_TAG_LEN;
            cfg_reg.onion_prefix_length  <= rpv_pkg::RST_ONION_LEN;
            cfg_reg.garlic_prefix_length <= rpv_pkg::RST_GARLIC_LEN;
            cfg_reg.user_name_length     <= rpv_pkg::RST_USER_LEN;
            cfg_reg.max_request_bytes    <= rpv_pkg::RST_MAX_BYTES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/rpv_parser.sv -----
// Per-request token state and the verdict logic of the request path validator.
module rpv_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  rpv_pkg::cfg_t     cfg,
    input  logic              step,
    input  logic              kind,
    input  logic [7:0]        text_byte,
    output rpv_pkg::result_t  result
);

    localparam logic [2:0] TOKEN_CAP = 3'd6;
    localparam logic [8:0] CHAR_CAP  = 9'd256;
    localparam logic [9:0] BYTE_CAP  = 10'd1023;
    localparam logic [3:0] PHASE_CAP = 4'd15;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    localparam logic [7:0] CMD_WORDS [4][3] = '{
        '{8'h76, 8'h65, 8'h72},   // ver
        '{8'h6D, 8'h73, 8'h67},   // msg
        '{8'h72, 8'h63, 8'h70},   // rcp
        '{8'h61, 8'h63, 8'h6B}    // ack
    };
    localparam logic [7:0] ONION_SFX [5] = '{8'h6F, 8'h6E, 8'h69, 8'h6F, 8'h6E};
    localparam logic [7:0] GARLIC_SFX [7] =
        '{8'h62, 8'h33, 8'h32, 8'h2E, 8'h69, 8'h32, 8'h70};

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic is_b32(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h32 && c <= 8'h37);
    endfunction

    logic [9:0] byte_total_reg,     byte_total_next;
    logic       too_long_reg,       too_long_next;
    logic [2:0] token_number_reg,   token_number_next;
    logic [8:0] token_chars_reg,    token_chars_next;
    logic       inside_token_reg,   inside_token_next;
    logic [3:0] command_match_reg,  command_match_next;
    logic       chars_ok_reg,       chars_ok_next;
    logic       fields_ok_reg,      fields_ok_next;
    logic [3:0] host_phase_reg,     host_phase_next;
    logic [8:0] prefix_chars_reg,   prefix_chars_next;
    logic [1:0] suffix_match_reg,   suffix_match_next;
    logic       network_seen_reg,   network_seen_next;
    logic       text_ended_reg,     text_ended_next;

    // Effect of closing the current token.
    logic [3:0] fin_cmd;
    logic       fin_ok;
    logic       fin_fields;
    logic       fin_net;
    logic       host_onion;
    logic       host_garlic;

    always_comb
    begin
        fin_cmd     = command_match_reg;
        fin_ok      = 1'b1;
        fin_net     = network_seen_reg;
        host_onion  = (host_phase_reg == 4'd6) && suffix_match_reg[0] &&
                      (prefix_chars_reg == {1'b0, cfg.onion_prefix_length});
        host_garlic = (host_phase_reg == 4'd8) && suffix_match_reg[1] &&
                      (prefix_chars_reg == {1'b0, cfg.garlic_prefix_length});
        case (token_number_reg)
            3'd1:
            begin
                if (token_chars_reg != 9'd3)
                    fin_cmd = 4'd0;
            end
            3'd2: fin_ok = chars_ok_reg && (token_chars_reg == {1'b0, cfg.message_id_length});
            3'd3: fin_ok = chars_ok_reg && (token_chars_reg == {1'b0, cfg.tag_length});
            3'd4:
            begin
                fin_ok  = chars_ok_reg && (host_onion || host_garlic);
                fin_net = host_garlic;
            end
            3'd5: fin_ok = chars_ok_reg && (token_chars_reg == {1'b0, cfg.user_name_length});
            default: fin_ok = 1'b1;
        endcase
        fin_fields = fields_ok_reg && fin_ok;
    end

    // Effect of taking one non-slash character.
    logic [2:0] tk_num;
    logic [8:0] tk_chars;
    logic       tk_ok;
    logic [3:0] tk_phase;
    logic [8:0] tk_prefix;
    logic [1:0] tk_sfx;
    logic [3:0] tk_cmd;
    logic [3:0] sfx_pos;

    always_comb
    begin
        if (inside_token_reg)
        begin
            tk_num    = token_number_reg;
            tk_chars  = token_chars_reg;
            tk_ok     = chars_ok_reg;
            tk_phase  = host_phase_reg;
            tk_prefix = prefix_chars_reg;
            tk_sfx    = suffix_match_reg;
        end
        else
        begin
            tk_num    = (token_number_reg < TOKEN_CAP) ? token_number_reg + 3'd1
                                                       : token_number_reg;
            tk_chars  = 9'd0;
            tk_ok     = 1'b1;
            tk_phase  = 4'd0;
            tk_prefix = 9'd0;
            tk_sfx    = 2'd0;
        end
        tk_cmd  = command_match_reg;
        sfx_pos = tk_phase - 4'd1;

        case (tk_num)
            3'd1:
            begin
                if (tk_chars < 9'd3)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        if (CMD_WORDS[k][tk_chars[1:0]] != text_byte)
                            tk_cmd[k] = 1'b0;
                    end
                end
                else
                begin
                    tk_cmd = 4'd0;
                end
            end
            3'd2, 3'd3:
            begin
                if (!is_hex(text_byte))
                    tk_ok = 1'b0;
            end
            3'd4:
            begin
                if (tk_phase == 4'd0)
                begin
                    if (text_byte == CHAR_DOT)
                    begin
                        tk_phase = 4'd1;
                        tk_sfx   = 2'b11;
                    end
                    else
                    begin
                        if (!is_b32(text_byte))
                            tk_ok = 1'b0;
                        if (tk_prefix < CHAR_CAP)
                            tk_prefix = tk_prefix + 9'd1;
                    end
                end
                else
                begin
                    // Both suffixes are matched side by side, one character per byte.
                    if (sfx_pos >= 4'd5)
                        tk_sfx[0] = 1'b0;
                    else if (ONION_SFX[sfx_pos[2:0]] != text_byte)
                        tk_sfx[0] = 1'b0;
                    if (sfx_pos >= 4'd7)
                        tk_sfx[1] = 1'b0;
                    else if (GARLIC_SFX[sfx_pos[2:0]] != text_byte)
                        tk_sfx[1] = 1'b0;
                    if (tk_phase < PHASE_CAP)
                        tk_phase = tk_phase + 4'd1;
                end
            end
            3'd5:
            begin
                if (!is_b32(text_byte))
                    tk_ok = 1'b0;
            end
            default: tk_ok = tk_ok;
        endcase

        if (tk_chars < CHAR_CAP)
            tk_chars = tk_chars + 9'd1;
    end

    // Verdict for an end item, with the open token closed first.
    logic [3:0] jd_cmd;
    logic       jd_fields;
    logic       jd_net;

    always_comb
    begin
        jd_cmd    = inside_token_reg ? fin_cmd    : command_match_reg;
        jd_fields = inside_token_reg ? fin_fields : fields_ok_reg;
        jd_net    = inside_token_reg ? fin_net    : network_seen_reg;
        result.host_network = 1'b0;
        if (too_long_reg)
        begin
            result.verdict = rpv_pkg::VERDICT_BAD_REQUEST;
        end
        else if (token_number_reg == 3'd0 || token_number_reg >= TOKEN_CAP)
        begin
            result.verdict = rpv_pkg::VERDICT_BAD_FORMAT;
        end
        else
        begin
            case (jd_cmd)
                4'b0001:
                    result.verdict = (token_number_reg == 3'd1) ? rpv_pkg::VERDICT_VER_OK
                                                                : rpv_pkg::VERDICT_BAD_FORMAT;
                4'b0010:
                begin
                    if (token_number_reg == 3'd5 && jd_fields)
                    begin
                        result.verdict      = rpv_pkg::VERDICT_MSG_OK;
                        result.host_network = jd_net;
                    end
                    else
                    begin
                        result.verdict = rpv_pkg::VERDICT_BAD_FORMAT;
                    end
                end
                4'b0100:
                    result.verdict = (token_number_reg == 3'd3 && jd_fields)
                                     ? rpv_pkg::VERDICT_RCP_OK : rpv_pkg::VERDICT_BAD_FORMAT;
                4'b1000:
                    result.verdict = (token_number_reg == 3'd3 && jd_fields)
                                     ? rpv_pkg::VERDICT_ACK_OK : rpv_pkg::VERDICT_BAD_FORMAT;
                default: result.verdict = rpv_pkg::VERDICT_BAD_FORMAT;
            endcase
        end
    end

    always_comb
    begin
        byte_total_next    = byte_total_reg;
        too_long_next      = too_long_reg;
        token_number_next  = token_number_reg;
        token_chars_next   = token_chars_reg;
        inside_token_next  = inside_token_reg;
        command_match_next = command_match_reg;
        chars_ok_next      = chars_ok_reg;
        fields_ok_next     = fields_ok_reg;
        host_phase_next    = host_phase_reg;
        prefix_chars_next  = prefix_chars_reg;
        suffix_match_next  = suffix_match_reg;
        network_seen_next  = network_seen_reg;
        text_ended_next    = text_ended_reg;

        if (step)
        begin
            if (kind == rpv_pkg::KIND_END)
            begin
                byte_total_next    = 10'd0;
                too_long_next      = 1'b0;
                token_number_next  = 3'd0;
                token_chars_next   = 9'd0;
                inside_token_next  = 1'b0;
                command_match_next = 4'hF;
                chars_ok_next      = 1'b1;
                fields_ok_next     = 1'b1;
                host_phase_next    = 4'd0;
                prefix_chars_next  = 9'd0;
                suffix_match_next  = 2'd0;
                network_seen_next  = 1'b0;
                text_ended_next    = 1'b0;
            end
            else if (!text_ended_reg)
            begin
                if (text_byte == 8'd0)
                begin
                    // A zero byte ends the text; the rest of the request is dropped.
                    text_ended_next = 1'b1;
                end
                else
                begin
                    if (byte_total_reg >= cfg.max_request_bytes)
                        too_long_next = 1'b1;
                    if (byte_total_reg < BYTE_CAP)
                        byte_total_next = byte_total_reg + 10'd1;
                    if (text_byte == CHAR_SLASH)
                    begin
                        if (inside_token_reg)
                        begin
                            command_match_next = fin_cmd;
                            fields_ok_next     = fin_fields;
                            network_seen_next  = fin_net;
                            inside_token_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        inside_token_next  = 1'b1;
                        token_number_next  = tk_num;
                        token_chars_next   = tk_chars;
                        chars_ok_next      = tk_ok;
                        host_phase_next    = tk_phase;
                        prefix_chars_next  = tk_prefix;
                        suffix_match_next  = tk_sfx;
                        command_match_next = tk_cmd;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_total_reg    <= 10'd0;
            too_long_reg      <= 1'b0;
            token_number_reg  <= 3'd0;
            token_chars_reg   <= 9'd0;
            inside_token_reg  <= 1'b0;
            command_match_reg <= 4'hF;
            chars_ok_reg      <= 1'b1;
            fields_ok_reg     <= 1'b1;
            host_phase_reg    <= 4'd0;
            prefix_chars_reg  <= 9'd0;
            suffix_match_reg  <= 2'd0;
            network_seen_reg  <= 1'b0;
            text_ended_reg    <= 1'b0;
        end
        else
        begin
            byte_total_reg    <= byte_total_next;
            too_long_reg      <= too_long_next;
            token_number_reg  <= token_number_next;
            token_chars_reg   <= token_chars_next;
            inside_token_reg  <= inside_token_next;
            command_match_reg <= command_match_next;
            chars_ok_reg      <= chars_ok_next;
            fields_ok_reg     <= fields_ok_next;
            host_phase_reg    <= host_phase_next;
            prefix_chars_reg  <= prefix_chars_next;
            suffix_match_reg  <= suffix_match_next;
            network_seen_reg  <= network_seen_next;
            text_ended_reg    <= text_ended_next;
        end
    end

endmodule
